// File: hdl/diag_event_report_parser_core_macros.svh
// assertion macros for the event report parser checker
// expects clk and rst_n in the scope where a macro is used
`ifndef DIAG_EVENT_REPORT_PARSER_CORE_MACROS_SVH
`define DIAG_EVENT_REPORT_PARSER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define DERP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define DERP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/derp_pkg.sv
// shared types and constants for the event report parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package derp_pkg;

  // parse phases
  typedef enum logic [2:0] {
    PH_WAIT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_ID_LO,
    PH_ID_HI,
    PH_STAMP,
    PH_PLEN,
    PH_PAY
  } phase_t;

  // result kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // payload code that means a length byte follows the timestamp
  localparam logic [1:0] PAY_CODE_LEN = 2'd3;

  // id word layout
  localparam int ID_TRUNC_BIT = 15;
  localparam int CODE_LO_BIT  = 13;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
  } in_word_t;

  // result word
  typedef struct packed {
    logic        result_kind;
    logic [11:0] rec_id;
    logic        ts_truncated;
    logic [63:0] timestamp;
    logic [7:0]  payload_count;
    logic [7:0]  payload_byte;
    logic        record_last;
  } out_word_t;

  // queue status seen by the top level and the back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

`default_nettype wire

// File: hdl/derp_front.sv
// front: byte parser that classifies each byte and builds result words
// depends on derp_pkg
`timescale 1ns / 1ps
`default_nettype none

module derp_front import derp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      acc,
  input  wire in_word_t  in_word,
  output logic           res_valid,
  output out_word_t      res_word
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] area_rem_r, area_rem_nxt;
  logic [2:0]  byte_cnt_r, byte_cnt_nxt;
  logic [15:0] id_word_r, id_word_nxt;
  logic [63:0] stamp_r, stamp_nxt;
  logic [7:0]  pay_rem_r, pay_rem_nxt;
  logic [1:0]  pay_code_r, pay_code_nxt;

  logic [7:0]  b;
  logic [15:0] area_dec;
  logic [7:0]  pay_dec;
  logic [15:0] len_full;
  logic        ts_last;
  logic [63:0] stamp_merge;
  phase_t      end_phase;

  assign b         = in_word.in_byte;
  assign area_dec  = (area_rem_r != 16'd0) ? area_rem_r - 16'd1 : 16'd0;
  assign pay_dec   = (pay_rem_r != 8'd0) ? pay_rem_r - 8'd1 : 8'd0;
  assign len_full  = {b, area_rem_r[7:0]};
  assign ts_last   = id_word_r[ID_TRUNC_BIT] ? (byte_cnt_r == 3'd1) : (byte_cnt_r == 3'd7);
  assign end_phase = (area_dec != 16'd0) ? PH_ID_LO : PH_WAIT;

  // drop the byte into its timestamp lane
  always_comb begin
    stamp_merge = stamp_r;
    for (int i = 0; i < 8; i++) begin
      if (byte_cnt_r == 3'(i)) begin
        stamp_merge[8*i +: 8] = stamp_r[8*i +: 8] | b;
      end
    end
  end

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    area_rem_nxt = area_rem_r;
    byte_cnt_nxt = byte_cnt_r;
    id_word_nxt  = id_word_r;
    stamp_nxt    = stamp_r;
    pay_rem_nxt  = pay_rem_r;
    pay_code_nxt = pay_code_r;
    if (acc) begin
      if (in_word.frame_start) begin
        phase_nxt    = PH_LEN_LO;
        area_rem_nxt = 16'd0;
        byte_cnt_nxt = 3'd0;
        pay_rem_nxt  = 8'd0;
      end else begin
        unique case (phase_r)
          PH_WAIT: begin
          end
          PH_LEN_LO: begin
            area_rem_nxt = {8'd0, b};
            phase_nxt    = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            area_rem_nxt = len_full;
            phase_nxt    = (len_full != 16'd0) ? PH_ID_LO : PH_WAIT;
          end
          PH_ID_LO: begin
            area_rem_nxt = area_dec;
            id_word_nxt  = {8'd0, b};
            phase_nxt    = PH_ID_HI;
          end
          PH_ID_HI: begin
            area_rem_nxt = area_dec;
            id_word_nxt  = {b, id_word_r[7:0]};
            pay_code_nxt = b[CODE_LO_BIT-8 +: 2];
            stamp_nxt    = 64'd0;
            byte_cnt_nxt = 3'd0;
            phase_nxt    = PH_STAMP;
          end
          PH_STAMP: begin
            area_rem_nxt = area_dec;
            stamp_nxt    = stamp_merge;
            if (!ts_last) begin
              byte_cnt_nxt = byte_cnt_r + 3'd1;
            end else begin
              byte_cnt_nxt = 3'd0;
              if (pay_code_r == PAY_CODE_LEN) begin
                phase_nxt = PH_PLEN;
              end else begin
                pay_rem_nxt = {6'd0, pay_code_r};
                phase_nxt   = (pay_code_r == 2'd0) ? end_phase : PH_PAY;
              end
            end
          end
          PH_PLEN: begin
            area_rem_nxt = area_dec;
            pay_rem_nxt  = b;
            phase_nxt    = (b == 8'd0) ? end_phase : PH_PAY;
          end
          PH_PAY: begin
            area_rem_nxt = area_dec;
            pay_rem_nxt  = pay_dec;
            if (pay_dec == 8'd0) begin
              phase_nxt = end_phase;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result word
  always_comb begin
    res_valid              = 1'b0;
    res_word               = '0;
    res_word.rec_id        = id_word_r[11:0];
    res_word.ts_truncated  = id_word_r[ID_TRUNC_BIT];
    res_word.timestamp     = stamp_r;
    if (acc && !in_word.frame_start) begin
      unique case (phase_r)
        PH_STAMP: begin
          res_word.timestamp = stamp_merge;
          if (ts_last && (pay_code_r != PAY_CODE_LEN)) begin
            res_valid              = 1'b1;
            res_word.result_kind   = KIND_HEADER;
            res_word.payload_count = {6'd0, pay_code_r};
            res_word.record_last   = (pay_code_r == 2'd0);
          end
        end
        PH_PLEN: begin
          res_valid              = 1'b1;
          res_word.result_kind   = KIND_HEADER;
          res_word.payload_count = b;
          res_word.record_last   = (b == 8'd0);
        end
        PH_PAY: begin
          res_valid             = 1'b1;
          res_word.result_kind  = KIND_PAYLOAD;
          res_word.payload_byte = b;
          res_word.record_last  = (pay_dec == 8'd0);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT;
      area_rem_r <= 16'd0;
      byte_cnt_r <= 3'd0;
      id_word_r  <= 16'd0;
      stamp_r    <= 64'd0;
      pay_rem_r  <= 8'd0;
      pay_code_r <= 2'd0;
    end else begin
      phase_r    <= phase_nxt;
      area_rem_r <= area_rem_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      id_word_r  <= id_word_nxt;
      stamp_r    <= stamp_nxt;
      pay_rem_r  <= pay_rem_nxt;
      pay_code_r <= pay_code_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/derp_queue.sv
// result queue between parser front and output back
// depends on derp_pkg
`timescale 1ns / 1ps
`default_nettype none

module derp_queue import derp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_word_t push_word,
  input  wire logic      pop,
  output out_word_t      head_word,
  output q_stat_t        stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_word_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head_word      = slot_r[rd_ptr_r];
  assign stat.full      = (cnt_r == CNT_W'(DEPTH));
  assign stat.not_empty = (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/derp_back.sv
// back: output register that drains the queue onto the result channel
// depends on derp_pkg
`timescale 1ns / 1ps
`default_nettype none

module derp_back import derp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_stat_t   q_stat,
  input  wire out_word_t q_word,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r;

  // load when the register is empty or being taken this cycle
  assign q_pop = q_stat.not_empty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= q_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: hdl/diag_event_report_parser_core.sv
// top level of the event report parser: front parser, result queue, output register
// depends on derp_pkg, derp_front, derp_queue, derp_back
//
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_stall   in_word_t  (in_byte, frame_start)
//   out_     out  out_valid / out_stall out_word_t (header or payload result)
//
// one byte accepted per cycle while the result queue has room
// a result reaches out_ by way of the result queue and then the output register
// in_stall rises only when the queue (QUEUE_DEPTH entries) is full
// out_stall holds the output register; the parser keeps going until the queue fills
// synchronous active-low reset clears parser state, queue pointers and out_valid
`timescale 1ns / 1ps
`default_nettype none

module diag_event_report_parser_core import derp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  // byte input
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_data,
  // result output
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_data
);

  logic      acc;
  logic      res_valid;
  out_word_t res_word;
  out_word_t head_word;
  q_stat_t   q_stat;
  logic      q_pop;

  // stall the byte stream only on a full queue
  assign in_stall = q_stat.full;
  assign acc      = in_valid && !q_stat.full;

  // front: parses each accepted byte, at most one result word per byte
  derp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_word   (in_data),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  // queue decouples parsing from the output stall
  derp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_word (res_word),
    .pop       (q_pop),
    .head_word (head_word),
    .stat      (q_stat)
  );

  // back: registered result channel
  derp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_word    (head_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: hdl/diag_event_report_parser_core_checker.sv
// port-level checks on the event report parser result channel
// depends on derp_pkg and diag_event_report_parser_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "diag_event_report_parser_core_macros.svh"

module diag_event_report_parser_core_checker import derp_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data
);

  `DERP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_data), "stalled result word changed")
  `DERP_ASSERT_NOW(a_pay_count_zero, out_valid && (out_data.result_kind == KIND_PAYLOAD),
    out_data.payload_count == 8'd0, "payload word with nonzero count")
  `DERP_ASSERT_NOW(a_hdr_byte_zero, out_valid && (out_data.result_kind == KIND_HEADER),
    out_data.payload_byte == 8'd0, "header word with nonzero payload byte")
  `DERP_ASSERT_NOW(a_hdr_last, out_valid && (out_data.result_kind == KIND_HEADER),
    out_data.record_last == (out_data.payload_count == 8'd0), "header record_last mismatch")
  `DERP_ASSERT_NOW(a_trunc_stamp, out_valid && out_data.ts_truncated,
    out_data.timestamp[63:16] == 48'd0, "truncated timestamp wider than 16 bits")

endmodule

bind diag_event_report_parser_core diag_event_report_parser_core_checker u_checker (.*);

`default_nettype wire
